/* sv/u8u16_pkg.sv */
// shared types, constants and helpers for the utf-8 to utf-16 transcoder
package u8u16_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] REPL_CP      = 21'h00FFFD;
    localparam logic [CP_W-1:0] SUPP_BASE    = 21'h010000;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO_CP   = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI_CP   = 21'h00DFFF;
    localparam logic [5:0]      HI_SURR_TAG  = 6'b110110;
    localparam logic [5:0]      LO_SURR_TAG  = 6'b110111;

    // codes of the sequence length classes; class_min gives each one's minimum legal value
    localparam logic [1:0] CLASS_NONE = 2'd0;
    localparam logic [1:0] CLASS_TWO  = 2'd1;
    localparam logic [1:0] CLASS_THREE = 2'd2;
    localparam logic [1:0] CLASS_FOUR = 2'd3;

    // one decoded code point on its way to the encoder
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            last;
    } cp_evt_t;

    function automatic logic [CP_W-1:0] class_min(input logic [1:0] cls);
        logic [CP_W-1:0] m;
        unique case (cls)
            CLASS_NONE:  m = 21'h000000;
            CLASS_TWO:   m = 21'h000080;
            CLASS_THREE: m = 21'h000800;
            CLASS_FOUR:  m = 21'h010000;
            default:     m = 21'h000000;
        endcase
        return m;
    endfunction

endpackage

/* sv/utf8_to_utf16_transcoder.sv */
// top level of the utf-8 to utf-16 transcoder
//
// Input channel (s_): one utf-8 byte per transaction in s_in_byte, with
// s_message_end set on the last byte of a message. NUL is an ordinary byte.
// Output channel (m_): one utf-16 code unit per transaction in m_code_unit;
// m_run_last marks the last unit caused by one input byte, m_message_last the
// final unit of a message. Malformed input yields U+FFFD.
// Each byte gives zero, one or two units (two for code points above U+FFFF).
// Throughput: one byte per cycle while s_ready is high. A decoded code point
// enters a small queue in the cycle its byte is taken; the encoder drains one
// unit per cycle while m_ready allows, so a surrogate pair holds its output
// register for both of its units. The code point of a byte is written to the
// queue on the accepting edge; its first unit then enters the output register
// once that register is free. Reset (aresetn low, synchronous) empties the
// queue, drops any partial sequence and clears m_valid. When the receiver
// stalls, the output register holds its unit; bytes keep being taken until
// the queue of QUEUE_DEPTH code points is full, then s_ready falls.
module utf8_to_utf16_transcoder
    import u8u16_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  s_in_byte,
    input  logic        s_message_end,
    input  logic        s_valid,
    output logic        s_ready,
    output logic [15:0] m_code_unit,
    output logic        m_run_last,
    output logic        m_message_last,
    output logic        m_valid,
    input  logic        m_ready
);

    logic    q_full;
    logic    q_not_empty;
    logic    q_pop;
    logic    evt_valid;
    cp_evt_t evt;
    cp_evt_t q_head;
    logic    accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    u8u16_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_byte     (s_in_byte),
        .message_end (s_message_end),
        .accept      (accept),
        .evt_valid   (evt_valid),
        .evt         (evt)
    );

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (evt_valid),
        .push_data (evt),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    u8u16_encode u_encode (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .code_unit    (m_code_unit),
        .run_last     (m_run_last),
        .message_last (m_message_last),
        .out_valid    (m_valid),
        .out_ready    (m_ready)
    );

endmodule

/* sv/u8u16_decode.sv */
// front end: takes utf-8 bytes, tracks the open sequence, yields code points
module u8u16_decode
    import u8u16_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] in_byte,
    input  logic       message_end,
    input  logic       accept,
    output logic       evt_valid,
    output cp_evt_t    evt
);

    logic [CP_W-1:0] partial_reg, partial_next;
    logic [1:0]      rem_reg, rem_next;
    logic [1:0]      cls_reg, cls_next;
    logic [CP_W-1:0] shifted;
    logic [1:0]      rem_dec;

    assign shifted = {partial_reg[CP_W-7:0], in_byte[5:0]};
    assign rem_dec = rem_reg - 2'd1;

    always_comb begin
        partial_next = partial_reg;
        rem_next     = rem_reg;
        cls_next     = cls_reg;
        evt_valid    = 1'b0;
        evt.cp       = REPL_CP;
        evt.last     = message_end;
        if (accept) begin
            if (rem_reg != 2'd0) begin
                partial_next = '0;
                rem_next     = 2'd0;
                cls_next     = CLASS_NONE;
                if (in_byte[7:6] != 2'b10) begin
                    evt_valid = 1'b1;
                end else if (rem_dec != 2'd0) begin
                    if (message_end) begin
                        evt_valid = 1'b1;
                    end else begin
                        partial_next = shifted;
                        rem_next     = rem_dec;
                        cls_next     = cls_reg;
                    end
                end else begin
                    evt_valid = 1'b1;
                    if (!(shifted < class_min(cls_reg) || shifted > CP_MAX ||
                          (shifted >= SURR_LO_CP && shifted <= SURR_HI_CP))) begin
                        evt.cp = shifted;
                    end
                end
            end else begin
                priority if (in_byte[7] == 1'b0) begin
                    evt_valid = 1'b1;
                    evt.cp    = {13'd0, in_byte};
                end else if (in_byte[7:6] == 2'b10 || in_byte[7:3] == 5'b11111) begin
                    evt_valid = 1'b1;
                end else if (message_end) begin
                    // lead byte cut off by the end of the message
                    evt_valid = 1'b1;
                end else if (in_byte[7:4] == 4'b1111) begin
                    partial_next = {18'd0, in_byte[2:0]};
                    rem_next     = 2'd3;
                    cls_next     = CLASS_FOUR;
                end else if (in_byte[7:5] == 3'b111) begin
                    partial_next = {17'd0, in_byte[3:0]};
                    rem_next     = 2'd2;
                    cls_next     = CLASS_THREE;
                end else begin
                    partial_next = {16'd0, in_byte[4:0]};
                    rem_next     = 2'd1;
                    cls_next     = CLASS_TWO;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            rem_reg     <= 2'd0;
            cls_reg     <= CLASS_NONE;
        end else begin
            partial_reg <= partial_next;
            rem_reg     <= rem_next;
            cls_reg     <= cls_next;
        end
    end

    // a byte flagged as message end always closes the sequence
    a_end_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && message_end) |=> (rem_reg == 2'd0))
        else $error("sequence left open after message end");

    a_end_yields_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && message_end) |-> evt_valid)
        else $error("message end byte produced no code point");

endmodule

/* sv/u8u16_queue.sv */
// short code point queue between the decoder and the encoder
module u8u16_queue
    import u8u16_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  cp_evt_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    not_empty,
    output cp_evt_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cp_evt_t         slot_reg [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign head      = slot_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == LAST_PTR) ? '0 : wr_reg + PW'(1);
        end
        if (pop) begin
            rd_next = (rd_reg == LAST_PTR) ? '0 : rd_reg + PW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("queue written while full");

endmodule

/* sv/u8u16_encode.sv */
// back end: turns queued code points into utf-16 units behind an output register
module u8u16_encode
    import u8u16_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_not_empty,
    input  cp_evt_t     q_head,
    output logic        q_pop,
    output logic [15:0] code_unit,
    output logic        run_last,
    output logic        message_last,
    output logic        out_valid,
    input  logic        out_ready
);

    logic            valid_reg, valid_next;
    logic [15:0]     unit_reg, unit_next;
    logic            run_last_reg, run_last_next;
    logic            msg_last_reg, msg_last_next;
    logic            pend_reg, pend_next;
    logic [15:0]     low_reg, low_next;
    logic            low_last_reg, low_last_next;
    logic            slot_free;
    logic [CP_W-1:0] offset;

    assign slot_free = !valid_reg || out_ready;
    assign q_pop     = slot_free && !pend_reg && q_not_empty;
    assign offset    = q_head.cp - SUPP_BASE;

    always_comb begin
        valid_next    = valid_reg;
        unit_next     = unit_reg;
        run_last_next = run_last_reg;
        msg_last_next = msg_last_reg;
        pend_next     = pend_reg;
        low_next      = low_reg;
        low_last_next = low_last_reg;
        if (slot_free) begin
            valid_next = 1'b0;
            if (pend_reg) begin
                valid_next    = 1'b1;
                unit_next     = low_reg;
                run_last_next = 1'b1;
                msg_last_next = low_last_reg;
                pend_next     = 1'b0;
            end else if (q_not_empty) begin
                valid_next = 1'b1;
                if (q_head.cp < SUPP_BASE) begin
                    unit_next     = q_head.cp[15:0];
                    run_last_next = 1'b1;
                    msg_last_next = q_head.last;
                end else begin
                    // surrogate pair: high half now, low half next
                    unit_next     = {HI_SURR_TAG, offset[19:10]};
                    run_last_next = 1'b0;
                    msg_last_next = 1'b0;
                    pend_next     = 1'b1;
                    low_next      = {LO_SURR_TAG, offset[9:0]};
                    low_last_next = q_head.last;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        unit_reg     <= unit_next;
        run_last_reg <= run_last_next;
        msg_last_reg <= msg_last_next;
        low_reg      <= low_next;
        low_last_reg <= low_last_next;
    end

    assign out_valid    = valid_reg;
    assign code_unit    = unit_reg;
    assign run_last     = run_last_reg;
    assign message_last = msg_last_reg;

    // a high surrogate transaction is followed at once by its low half
    a_pair_in_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && out_ready && !run_last_reg)
            |=> (valid_reg && unit_reg[15:10] == LO_SURR_TAG && run_last_reg))
        else $error("low surrogate did not follow high surrogate");

    a_msg_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && msg_last_reg) |-> run_last_reg)
        else $error("message end flagged on a unit that does not close its byte");

endmodule

/* dv/tb_utf8_to_utf16_transcoder.sv */
// self-checking testbench for the utf-8 to utf-16 transcoder
module tb_utf8_to_utf16_transcoder;
    import u8u16_pkg::*;

    typedef struct {
        logic [15:0] unit;
        logic        run_last;
        logic        msg_last;
    } utf16_unit_t;

    // predicts the units of every accepted byte and checks them in order
    class utf16_scoreboard;
        utf16_unit_t     expected_units[$];
        logic [CP_W-1:0] cp_acc;
        logic [1:0]      cont_due;
        logic [1:0]      seq_class;
        logic [CP_W-1:0] class_floor[4];
        int              n_errors;
        int              n_bytes;
        int              n_units;
        int              n_repl;
        int              n_pairs;

        function new();
            class_floor[CLASS_NONE]  = 21'h000000;
            class_floor[CLASS_TWO]   = 21'h000080;
            class_floor[CLASS_THREE] = 21'h000800;
            class_floor[CLASS_FOUR]  = 21'h010000;
            cp_acc    = '0;
            cont_due  = 2'd0;
            seq_class = CLASS_NONE;
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            n_errors++;
        endtask

        function int pending();
            return expected_units.size();
        endfunction

        function void drop_sequence();
            cp_acc    = '0;
            cont_due  = 2'd0;
            seq_class = CLASS_NONE;
        endfunction

        function void push_units(input logic [CP_W-1:0] cp, input logic msg_end);
            utf16_unit_t     u;
            logic [CP_W-1:0] off;
            if (cp == REPL_CP) n_repl++;
            if (cp < SUPP_BASE) begin
                u.unit     = cp[15:0];
                u.run_last = 1'b1;
                u.msg_last = msg_end;
                expected_units.push_back(u);
            end else begin
                off        = cp - SUPP_BASE;
                u.unit     = {HI_SURR_TAG, off[19:10]};
                u.run_last = 1'b0;
                u.msg_last = 1'b0;
                expected_units.push_back(u);
                u.unit     = {LO_SURR_TAG, off[9:0]};
                u.run_last = 1'b1;
                u.msg_last = msg_end;
                expected_units.push_back(u);
                n_pairs++;
            end
        endfunction

        function void note_byte(input logic [7:0] b, input logic msg_end);
            logic [CP_W-1:0] cp;
            logic            done;
            cp   = '0;
            done = 1'b0;
            n_bytes++;
            if (cont_due != 2'd0) begin
                if (b[7:6] != 2'b10) begin
                    // broken sequence, the offending byte is swallowed
                    drop_sequence();
                    cp   = REPL_CP;
                    done = 1'b1;
                end else begin
                    cp_acc   = {cp_acc[CP_W-7:0], b[5:0]};
                    cont_due = cont_due - 2'd1;
                    if (cont_due != 2'd0) begin
                        if (msg_end) begin
                            drop_sequence();
                            cp   = REPL_CP;
                            done = 1'b1;
                        end
                    end else begin
                        cp = cp_acc;
                        if (cp < class_floor[seq_class] || cp > CP_MAX ||
                            (cp >= SURR_LO_CP && cp <= SURR_HI_CP))
                            cp = REPL_CP;
                        drop_sequence();
                        done = 1'b1;
                    end
                end
            end else if (!b[7]) begin
                cp   = {13'd0, b};
                done = 1'b1;
            end else if (b < 8'hC0 || b >= 8'hF8) begin
                cp   = REPL_CP;
                done = 1'b1;
            end else begin
                if (b >= 8'hF0) begin
                    cp_acc    = {18'd0, b[2:0]};
                    cont_due  = 2'd3;
                    seq_class = CLASS_FOUR;
                end else if (b >= 8'hE0) begin
                    cp_acc    = {17'd0, b[3:0]};
                    cont_due  = 2'd2;
                    seq_class = CLASS_THREE;
                end else begin
                    cp_acc    = {16'd0, b[4:0]};
                    cont_due  = 2'd1;
                    seq_class = CLASS_TWO;
                end
                if (msg_end) begin
                    drop_sequence();
                    cp   = REPL_CP;
                    done = 1'b1;
                end
            end
            if (done) push_units(cp, msg_end);
        endfunction

        task check_unit(input logic [15:0] unit, input logic run_last,
                        input logic msg_last);
            utf16_unit_t exp_u;
            n_units++;
            if (expected_units.size() == 0) begin
                report($sformatf("unit %h arrived with nothing expected", unit));
            end else begin
                exp_u = expected_units.pop_front();
                if (unit !== exp_u.unit)
                    report($sformatf("code unit %h, expected %h", unit, exp_u.unit));
                if (run_last !== exp_u.run_last)
                    report($sformatf("run_last %b on unit %h, expected %b",
                                     run_last, exp_u.unit, exp_u.run_last));
                if (msg_last !== exp_u.msg_last)
                    report($sformatf("message_last %b on unit %h, expected %b",
                                     msg_last, exp_u.unit, exp_u.msg_last));
            end
        endtask

        task check_leftovers();
            if (expected_units.size() != 0)
                report($sformatf("%0d units never arrived", expected_units.size()));
        endtask
    endclass

    logic        aclk;
    logic        aresetn        = 1'b0;
    logic [7:0]  s_in_byte      = 8'h00;
    logic        s_message_end  = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [15:0] m_code_unit;
    logic        m_run_last;
    logic        m_message_last;
    logic        m_valid;
    logic        m_ready        = 1'b0;

    utf16_scoreboard sb;
    logic [7:0]      seq_q[$];
    logic [7:0]      msg_q[$];
    int              src_burst = 0;
    int              snk_burst = 0;
    int              n_msgs    = 0;

    utf8_to_utf16_transcoder u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_in_byte      (s_in_byte),
        .s_message_end  (s_message_end),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .m_code_unit    (m_code_unit),
        .m_run_last     (m_run_last),
        .m_message_last (m_message_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // bursts of back-to-back transactions between stretches of random gaps
    function automatic int draw_gap(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            burst = $urandom_range(10, 40);
            return 0;
        end
        if ($urandom_range(0, 1) == 1) return $urandom_range(0, 2);
        return $urandom_range(0, 14);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic msg_end);
        int gap;
        gap = draw_gap(src_burst);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_in_byte     <= b;
        s_message_end <= msg_end;
        do @(posedge aclk); while (!s_ready);
        sb.note_byte(b, msg_end);
    endtask

    // hold the sender back until the output side has caught up
    task automatic drain_units();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [CP_W-1:0] span_lo(input int len);
        case (len)
            1:       return 21'h000000;
            2:       return 21'h000080;
            3:       return 21'h000800;
            default: return 21'h010000;
        endcase
    endfunction

    function automatic logic [CP_W-1:0] span_hi(input int len);
        case (len)
            1:       return 21'h00007F;
            2:       return 21'h0007FF;
            3:       return 21'h00FFFF;
            default: return 21'h10FFFF;
        endcase
    endfunction

    // one code point into seq_q, mostly well formed, sometimes damaged
    task automatic build_cp();
        int              kind;
        int              len;
        int              k;
        logic [CP_W-1:0] cp;
        logic [7:0]      r;
        seq_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 30)      len = 1;
        else if (kind < 50) len = 2;
        else if (kind < 70) len = 3;
        else if (kind < 85) len = 4;
        else                len = $urandom_range(2, 4);
        if (kind >= 85 && kind < 88) begin
            cp = CP_W'($urandom_range(0, span_lo(len) - 1));
        end else if (kind >= 88 && kind < 90) begin
            len = 4;
            cp  = CP_W'($urandom_range(21'h110000, 21'h1FFFFF));
        end else begin
            cp = CP_W'($urandom_range(span_lo(len), span_hi(len)));
        end
        case (len)
            1: seq_q.push_back({1'b0, cp[6:0]});
            2: begin
                seq_q.push_back({3'b110, cp[10:6]});
                seq_q.push_back({2'b10, cp[5:0]});
            end
            3: begin
                seq_q.push_back({4'b1110, cp[15:12]});
                seq_q.push_back({2'b10, cp[11:6]});
                seq_q.push_back({2'b10, cp[5:0]});
            end
            default: begin
                seq_q.push_back({5'b11110, cp[20:18]});
                seq_q.push_back({2'b10, cp[17:12]});
                seq_q.push_back({2'b10, cp[11:6]});
                seq_q.push_back({2'b10, cp[5:0]});
            end
        endcase
        if (kind >= 90 && kind < 93) begin
            k = $urandom_range(1, len - 1);
            repeat (k) void'(seq_q.pop_back());
        end else if (kind >= 93 && kind < 96) begin
            k = $urandom_range(1, len - 1);
            r = 8'($urandom_range(0, 255));
            if (r[7:6] == 2'b10) r[6] = 1'b1;
            seq_q[k] = r;
        end else if (kind >= 96) begin
            seq_q.delete();
            seq_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_unit(m_code_unit, m_run_last, m_message_last);
    end

    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            gap = draw_gap(snk_burst);
            @(negedge aclk);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    initial begin
        int n_cp;
        sb = new();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // U+0000, U+007F, U+0080, U+FFFF, U+10FFFF, then malformed forms
        send_byte(8'h00, 1'b0); send_byte(8'h7F, 1'b1);
        send_byte(8'hC2, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
        send_byte(8'hF4, 1'b0); send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b1);
        // stray continuation, invalid leads
        send_byte(8'h80, 1'b0); send_byte(8'hFF, 1'b0); send_byte(8'hF8, 1'b0);
        // bad continuation swallows the ascii byte
        send_byte(8'hC3, 1'b0); send_byte(8'h41, 1'b0);
        // overlong, encoded surrogate, above the code space
        send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
        send_byte(8'hF4, 1'b0); send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0); send_byte(8'h80, 1'b0);
        // cut off mid sequence and on a lead byte
        send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b0); send_byte(8'h80, 1'b1);
        send_byte(8'hE2, 1'b1);
        drain_units();

        while (sb.n_bytes < 830) begin
            msg_q.delete();
            n_cp = $urandom_range(1, 10);
            repeat (n_cp) begin
                build_cp();
                foreach (seq_q[j]) msg_q.push_back(seq_q[j]);
            end
            foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1);
            n_msgs++;
            if ($urandom_range(0, 14) == 0) drain_units();
        end

        drain_units();
        repeat (16) @(posedge aclk);
        sb.check_leftovers();
        $display("summary: %0d bytes in %0d random messages plus directed cases, %0d units checked",
                 sb.n_bytes, n_msgs, sb.n_units);
        $display("summary: %0d replacement units, %0d surrogate pairs",
                 sb.n_repl, sb.n_pairs);
        if (sb.n_errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
